// File: hw/rtl/round_robin_buffer_pool_defines.svh
// ----------------------------------------------------------------------------
// Round-robin buffer pool: assertion macros
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_BUFFER_POOL_DEFINES_SVH
`define ROUND_ROBIN_BUFFER_POOL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define RRBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrbp assertion failed");
// Next-cycle implication, checked out of reset.
`define RRBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrbp assertion failed");
`else
`define RRBP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RRBP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/rrbp_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin buffer pool: package
// Widths, codes and beat types shared by the pool modules.
// ----------------------------------------------------------------------------
package rrbp_pkg;

    localparam int MAX_BUFFERS = 64;
    localparam int SLOT_W      = $clog2(MAX_BUFFERS);
    localparam int CNT_W       = $clog2(MAX_BUFFERS + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = CNT_W;

    typedef enum logic [1:0] {
        CMD_ACQUIRE      = 2'd0,
        CMD_RELEASE      = 2'd1,
        CMD_RELEASE_LAST = 2'd2,
        CMD_CLEAR        = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DISABLED = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOT_BUSY = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_ENABLE = 1'b0,
        CFG_N_BUFFERS   = 1'b1
    } t_cfg_index;

    // Operations of the shared slot arithmetic unit
    typedef enum logic [1:0] {
        OP_MOD = 2'd0,
        OP_INC = 2'd1,
        OP_DEC = 2'd2
    } t_slot_op;

    typedef struct packed {
        logic [CNT_W-1:0] value;
        logic             hit;
    } t_slot_res;

    typedef struct packed {
        t_cmd_code         cmd;
        logic [SLOT_W-1:0] buf_index;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  busy_count;
    } t_res;

endpackage

// File: hw/rtl/round_robin_buffer_pool.sv
// ----------------------------------------------------------------------------
// Round-robin buffer pool allocator
// Busy flag per slot plus a rotating next pointer; acquire, release by index,
// release-last and clear, each answered with one result beat.
// ----------------------------------------------------------------------------
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+------------------------------
//  command   | start, busy, i_cmd                 | taken when start && !busy
//  result    | o_valid, o_res                     | one-cycle strobe, no stall
//  config    | i_cfg_we, i_cfg_index, i_cfg_data  | written when i_cfg_we
//
//  A command runs from accept through NORM, which subtracts the slot count
//  from the stored pointer until it lies below it (no steps unless the pool
//  shrank), and EXEC to the result strobe; an acquire goes on from EXEC to
//  SCAN, one slot probed per cycle from the pointer, 1 to the clamped slot count.
//  The shared slot unit (one compare and add) serves NORM, SCAN and release-last.
//  Reset (synchronous, active low) frees all slots, zeroes the pointer and
//  count, disables the pool and sets the slot count to 64.
//  The result beat cannot be held off; busy drops in the strobe cycle.
// ----------------------------------------------------------------------------
`include "round_robin_buffer_pool_defines.svh"

module round_robin_buffer_pool
    import rrbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_cmd                  i_cmd,
    output logic                  o_valid,
    output t_res                  o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NORM = 4'b0010,
        S_EXEC = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    // Control state
    t_state                r_state,       n_state;
    logic [MAX_BUFFERS-1:0] r_busy_flags, n_busy_flags;
    logic [SLOT_W-1:0]     r_next_slot,   n_next_slot;
    logic [CNT_W-1:0]      r_busy_total,  n_busy_total;
    logic                  r_pool_enable;
    logic [CNT_W-1:0]      r_n_buffers;
    logic                  r_valid,       n_valid;

    // Working registers of the current command
    t_cmd                  r_cmd,         n_cmd;
    logic [CNT_W-1:0]      r_ptr,         n_ptr;
    logic [CNT_W-1:0]      r_cnt,         n_cnt;
    t_res                  r_res,         n_res;

    logic [CNT_W-1:0]      slot_cnt;
    t_slot_op              unit_op;
    t_slot_res             unit_res;
    logic [SLOT_W-1:0]     last_slot;

    // Clamp the slot count register to 1..MAX_BUFFERS
    always_comb begin
        if (r_n_buffers == '0) begin
            slot_cnt = CNT_W'(1);
        end else if (r_n_buffers > CNT_W'(MAX_BUFFERS)) begin
            slot_cnt = CNT_W'(MAX_BUFFERS);
        end else begin
            slot_cnt = r_n_buffers;
        end
    end

    // Pick the unit operation for the current step
    always_comb begin
        case (r_state)
            S_NORM:  unit_op = OP_MOD;
            S_SCAN:  unit_op = OP_INC;
            default: unit_op = OP_DEC;
        endcase
    end

    rrbp_slot_unit u_slot_unit (
        .i_op  (unit_op),
        .i_a   (r_ptr),
        .i_n   (slot_cnt),
        .o_res (unit_res)
    );

    assign last_slot = unit_res.value[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_busy_flags = r_busy_flags;
        n_next_slot  = r_next_slot;
        n_busy_total = r_busy_total;
        n_cmd        = r_cmd;
        n_ptr        = r_ptr;
        n_cnt        = r_cnt;
        n_valid      = 1'b0;
        n_res        = r_res;

        case (r_state)
            S_IDLE: begin
                // Take the command beat and start from the stored pointer
                if (start) begin
                    n_cmd   = i_cmd;
                    n_ptr   = {1'b0, r_next_slot};
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // Subtract the slot count until the pointer lies inside the pool
                if (unit_res.hit) begin
                    n_ptr = unit_res.value;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state          = S_IDLE;
                n_valid          = 1'b1;
                n_res.status     = ST_OK;
                n_res.slot_index = '0;
                case (r_cmd.cmd)
                    CMD_ACQUIRE: begin
                        if (!r_pool_enable) begin
                            n_res.status = ST_DISABLED;
                        end else begin
                            // Hold the result back and probe slots from the pointer
                            n_valid = 1'b0;
                            n_cnt   = CNT_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                    CMD_RELEASE: begin
                        if ({1'b0, r_cmd.buf_index} >= slot_cnt) begin
                            n_res.status = ST_RANGE;
                        end else if (!r_busy_flags[r_cmd.buf_index]) begin
                            n_res.status = ST_NOT_BUSY;
                        end else begin
                            n_busy_flags[r_cmd.buf_index] = 1'b0;
                            n_busy_total = r_busy_total - CNT_W'(1);
                        end
                    end
                    CMD_RELEASE_LAST: begin
                        // Step the pointer back one slot, whether or not it frees
                        if (r_busy_flags[last_slot]) begin
                            n_busy_flags[last_slot] = 1'b0;
                            n_busy_total = r_busy_total - CNT_W'(1);
                        end else begin
                            n_res.status = ST_NOT_BUSY;
                        end
                        n_next_slot      = last_slot;
                        n_res.slot_index = last_slot;
                    end
                    CMD_CLEAR: begin
                        n_busy_flags = '0;
                        n_busy_total = '0;
                        n_next_slot  = '0;
                    end
                    default: begin
                        n_res.status = ST_OK;
                    end
                endcase
                n_res.busy_count = n_busy_total;
            end
            S_SCAN: begin
                if (!r_busy_flags[r_ptr[SLOT_W-1:0]]) begin
                    // Grant this slot and advance the pointer past it
                    n_busy_flags[r_ptr[SLOT_W-1:0]] = 1'b1;
                    n_busy_total     = r_busy_total + CNT_W'(1);
                    n_next_slot      = unit_res.value[SLOT_W-1:0];
                    n_res.status     = ST_OK;
                    n_res.slot_index = r_ptr[SLOT_W-1:0];
                    n_res.busy_count = n_busy_total;
                    n_valid          = 1'b1;
                    n_state          = S_IDLE;
                end else if (r_cnt == slot_cnt) begin
                    // Every slot probed: report a full pool, pointer unchanged
                    n_res.status     = ST_FULL;
                    n_res.slot_index = '0;
                    n_res.busy_count = r_busy_total;
                    n_valid          = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_ptr = unit_res.value;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_busy_flags  <= '0;
            r_next_slot   <= '0;
            r_busy_total  <= '0;
            r_pool_enable <= 1'b0;
            r_n_buffers   <= CNT_W'(MAX_BUFFERS);
            r_valid       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy_flags <= n_busy_flags;
            r_next_slot  <= n_next_slot;
            r_busy_total <= n_busy_total;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_ENABLE: r_pool_enable <= i_cfg_data[0];
                    CFG_N_BUFFERS:   r_n_buffers   <= i_cfg_data;
                    default:         r_pool_enable <= r_pool_enable;
                endcase
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_ptr <= n_ptr;
        r_cnt <= n_cnt;
        r_res <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // The result strobe comes with the return to idle
    `RRBP_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !busy)
    // An accepted command always occupies the block in the next cycle
    `RRBP_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid)
    // The busy count tracks the flags exactly
    `RRBP_ASSERT_IMP(a_count_flags, i_clk, i_rst_n, 1'b1, r_busy_total == CNT_W'($countones(r_busy_flags)))

endmodule

// File: hw/rtl/rrbp_slot_unit.sv
// ----------------------------------------------------------------------------
// Round-robin buffer pool: slot arithmetic unit
// One compare-and-add path: modulo step, wrapping increment, wrapping decrement.
// ----------------------------------------------------------------------------
module rrbp_slot_unit
    import rrbp_pkg::*;
(
    input  t_slot_op         i_op,
    input  logic [CNT_W-1:0] i_a,
    input  logic [CNT_W-1:0] i_n,
    output t_slot_res        o_res
);

    logic [CNT_W-1:0] a_inc;

    assign a_inc = i_a + CNT_W'(1);

    always_comb begin
        o_res = '0;
        case (i_op)
            OP_MOD: begin
                // one restoring step toward a mod n
                if (i_a >= i_n) begin
                    o_res.value = i_a - i_n;
                    o_res.hit   = 1'b1;
                end else begin
                    o_res.value = i_a;
                end
            end
            OP_INC: begin
                o_res.hit   = (a_inc == i_n);
                o_res.value = (a_inc == i_n) ? '0 : a_inc;
            end
            OP_DEC: begin
                o_res.hit   = (i_a == '0);
                o_res.value = (i_a == '0) ? (i_n - CNT_W'(1)) : (i_a - CNT_W'(1));
            end
            default: begin
                o_res.value = i_a;
            end
        endcase
    end

endmodule

// File: verif/pool_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool checker
// Mirrors the pool's slot flags, pointer and busy count from the command and
// config beats it sees, and compares every result beat with the prediction.
// ----------------------------------------------------------------------------
module pool_alloc_checker
    import rrbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  t_cmd                  i_cmd,
    input  logic                  i_valid,
    input  t_res                  i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    bit                slot_taken [MAX_BUFFERS];
    logic [SLOT_W-1:0] rover;
    logic [CNT_W-1:0]  taken_total;
    bit                pool_on;
    logic [CNT_W-1:0]  slots_cfg;

    t_res answers_due[$];
    t_res want;
    int   fails = 0;

    // Apply one command to the mirrored pool and return the answer it gives.
    function automatic t_res pool_answer(t_cmd c);
        int   n;
        int   ptr;
        int   s;
        int   i;
        bit   found;
        t_res r;
        n = (slots_cfg == 0) ? 1 : ((slots_cfg > MAX_BUFFERS) ? MAX_BUFFERS : int'(slots_cfg));
        ptr = int'(rover) % n;
        r.status = ST_OK;
        r.slot_index = '0;
        case (c.cmd)
            CMD_ACQUIRE: begin
                if (!pool_on) begin
                    r.status = ST_DISABLED;
                end else begin
                    found = 1'b0;
                    for (i = 0; i < n && !found; i++) begin
                        s = (ptr + i) % n;
                        if (!slot_taken[s]) begin
                            slot_taken[s] = 1'b1;
                            taken_total = taken_total + 1'b1;
                            rover = SLOT_W'((s + 1) % n);
                            r.slot_index = SLOT_W'(s);
                            found = 1'b1;
                        end
                    end
                    if (!found) r.status = ST_FULL;
                end
            end
            CMD_RELEASE: begin
                if (int'(c.buf_index) >= n) begin
                    r.status = ST_RANGE;
                end else if (!slot_taken[c.buf_index]) begin
                    r.status = ST_NOT_BUSY;
                end else begin
                    slot_taken[c.buf_index] = 1'b0;
                    taken_total = taken_total - 1'b1;
                end
            end
            CMD_RELEASE_LAST: begin
                s = (ptr == 0) ? n - 1 : ptr - 1;
                if (slot_taken[s]) begin
                    slot_taken[s] = 1'b0;
                    taken_total = taken_total - 1'b1;
                end else begin
                    r.status = ST_NOT_BUSY;
                end
                rover = SLOT_W'(s);
                r.slot_index = SLOT_W'(s);
            end
            default: begin
                foreach (slot_taken[j]) slot_taken[j] = 1'b0;
                taken_total = '0;
                rover = '0;
            end
        endcase
        r.busy_count = taken_total;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_taken[j]) slot_taken[j] = 1'b0;
            rover = '0;
            taken_total = '0;
            pool_on = 1'b0;
            slots_cfg = CNT_W'(MAX_BUFFERS);
            answers_due.delete();
        end else begin
            if (i_valid) begin
                if (answers_due.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fails++;
                end else begin
                    want = answers_due.pop_front();
                    if (i_res.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res.status);
                        fails++;
                    end
                    if (i_res.slot_index !== want.slot_index) begin
                        $error("slot_index mismatch: expected %0d, actual %0d",
                               want.slot_index, i_res.slot_index);
                        fails++;
                    end
                    if (i_res.busy_count !== want.busy_count) begin
                        $error("busy_count mismatch: expected %0d, actual %0d",
                               want.busy_count, i_res.busy_count);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                // Queue the predicted answer behind any still outstanding
                want = pool_answer(i_cmd);
                answers_due.insert(answers_due.size(), want);
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_POOL_ENABLE: pool_on = i_cfg_data[0];
                    default:         slots_cfg = i_cfg_data;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= answers_due.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool testbench top
// Drives command and config beats into the round-robin pool allocator: a
// directed opening, then random phases over several pool sizes and enables.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
    import rrbp_pkg::*;

    // Run ceiling: the slowest command plus a long pause,
    // times roughly a thousand commands, with ample margin on top.
    localparam int CYCLE_LIMIT = 1500000;
    // Covers the worst accept-to-strobe time: pointer fixup plus full scan.
    localparam int DRAIN_CYCLES = 150;
    localparam int NUM_PHASES = 9;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    t_cmd                  i_cmd = '0;
    logic                  o_valid;
    t_res                  o_res;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int beats_sent = 0;

    // Random phases: enable, slot count, length, acquire and clear percentages.
    // The slot counts shrink and grow the pool without clearing it first, so the
    // pointer can land beyond the pool and stale busy slots sit above it. Zero
    // and 127 hit the clamping of the slot count; the last phase has no
    // clears and leans on acquire to drive the full pool case.
    int ph_en  [NUM_PHASES] = '{1,   1,   1,  1,  0,  1,   1,   1,   1};
    int ph_n   [NUM_PHASES] = '{64,  5,   1,  0,  16, 2,   127, 33,  64};
    int ph_cnt [NUM_PHASES] = '{180, 100, 60, 40, 60, 80,  100, 120, 180};
    int ph_acq [NUM_PHASES] = '{60,  45,  50, 50, 40, 50,  55,  50,  85};
    int ph_clr [NUM_PHASES] = '{2,   3,   3,  3,  5,  3,   3,   3,   0};

    round_robin_buffer_pool i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pool_alloc_checker pool_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop if a beat never shows up.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Drop start for a while about 22 times in a hundred beats. Pauses are
    // mostly short, now and then long enough to span a full scan, so they
    // land on every phase of the block's work. Beats 400 to 559 run back to
    // back with no pause at all.
    task automatic maybe_pause();
        int len;
        if (beats_sent >= 400 && beats_sent < 560) return;
        if ($urandom_range(0, 99) < 22) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 140)
                                              : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (len) @(posedge i_clk);
        end
    endtask

    // Present one command beat and hold it until the block takes it: the
    // beat goes in at the edge where start is high and busy is low. Start
    // stays high into the next beat unless a pause drops it.
    task automatic send_cmd(input t_cmd_code c, input int idx);
        start <= 1'b1;
        i_cmd <= t_cmd'{cmd: c, buf_index: idx[SLOT_W-1:0]};
        do @(posedge i_clk); while (busy);
        beats_sent++;
        maybe_pause();
    endtask

    // Hold off until every result beat is back, then write both registers.
    // Every command answers once, so an empty expectation queue means idle.
    task automatic set_pool(input bit en, input int n);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POOL_ENABLE;
        i_cfg_data  <= CFG_DATA_W'(en);
        @(posedge i_clk);
        i_cfg_index <= CFG_N_BUFFERS;
        i_cfg_data  <= n[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int        p;
        int        k;
        int        eff;
        int        roll;
        int        idx;
        t_cmd_code c;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the pool is disabled with 64 slots: acquire refused,
        // releases of free slots flagged, release-last wraps from slot 0 to 63.
        send_cmd(CMD_ACQUIRE, 63);
        send_cmd(CMD_RELEASE, 0);
        send_cmd(CMD_RELEASE, 63);
        send_cmd(CMD_RELEASE_LAST, 0);
        send_cmd(CMD_CLEAR, 63);

        // Small pool, pointer cleared to 0: fill it, overflow it, release at
        // and past the range edge, release twice, step the pointer back.
        set_pool(1'b1, 4);
        repeat (4) send_cmd(CMD_ACQUIRE, 0);
        send_cmd(CMD_ACQUIRE, 63);
        send_cmd(CMD_RELEASE, 63);
        send_cmd(CMD_RELEASE, 4);
        send_cmd(CMD_RELEASE, 3);
        send_cmd(CMD_RELEASE, 3);
        send_cmd(CMD_RELEASE_LAST, 0);
        send_cmd(CMD_RELEASE_LAST, 63);
        send_cmd(CMD_ACQUIRE, 0);

        // Grow back to the full pool with slots still busy.
        set_pool(1'b1, 64);
        send_cmd(CMD_ACQUIRE, 0);
        send_cmd(CMD_ACQUIRE, 63);
        send_cmd(CMD_RELEASE, 63);
        send_cmd(CMD_RELEASE_LAST, 0);
        send_cmd(CMD_CLEAR, 0);
        send_cmd(CMD_CLEAR, 63);

        for (p = 0; p < NUM_PHASES; p++) begin
            set_pool(ph_en[p] != 0, ph_n[p]);
            eff = (ph_n[p] == 0) ? 1 : ((ph_n[p] > MAX_BUFFERS) ? MAX_BUFFERS : ph_n[p]);
            for (k = 0; k < ph_cnt[p]; k++) begin
                roll = $urandom_range(0, 99);
                if (roll >= 100 - ph_clr[p])
                    c = CMD_CLEAR;
                else if (roll < ph_acq[p])
                    c = CMD_ACQUIRE;
                else if (roll < ph_acq[p] + (100 - ph_clr[p] - ph_acq[p]) * 2 / 3)
                    c = CMD_RELEASE;
                else
                    c = CMD_RELEASE_LAST;
                // Releases mostly target slots inside the pool; the rest sweep the whole
                // index field, which also covers the out-of-range answer.
                if (c == CMD_RELEASE && $urandom_range(0, 3) != 0)
                    idx = $urandom_range(0, eff - 1);
                else
                    idx = $urandom_range(0, 63);
                send_cmd(c, idx);
            end
        end

        // Drop start, wait out the last results, then give stray beats a chance.
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: round_robin_buffer_pool.f
+incdir+hw/rtl
hw/rtl/rrbp_pkg.sv
hw/rtl/rrbp_slot_unit.sv
hw/rtl/round_robin_buffer_pool.sv
verif/pool_alloc_checker.sv
verif/tb_top.sv
